>>> rtl/aes_sbox_compute_defines.svh
// Assertion macros for the S-box block.
// Each check runs on the rising edge of aclk.
`ifndef AES_SBOX_COMPUTE_DEFINES_SVH
`define AES_SBOX_COMPUTE_DEFINES_SVH

`ifndef SYNTHESIS

// Check that is switched off while reset is held.
`define ASC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check that also runs during reset.
`define ASC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`else

`define ASC_ASSERT(lbl, prop, msg)
`define ASC_ASSERT_RST(lbl, prop, msg)

`endif

`endif

>>> rtl/asc_pkg.sv
package asc_pkg;

    // AES field polynomial x^8+x^4+x^3+x+1 and the affine constant
    localparam logic [8:0] GF_POLY    = 9'h11B;
    localparam logic [7:0] AFFINE_ADD = 8'h63;

    // Fold a 15-bit carry-less product back into the field
    function automatic logic [7:0] gf_reduce(input logic [14:0] p);
        logic [14:0] r;
        r = p;
        for (int i = 14; i >= 8; i--) begin
            if (r[i]) begin
                r[i -: 9] = r[i -: 9] ^ GF_POLY;
            end
        end
        return r[7:0];
    endfunction

    // Squaring is linear: spread the bits, then reduce
    function automatic logic [7:0] gf_sq(input logic [7:0] a);
        logic [14:0] s;
        s = '0;
        for (int i = 0; i < 8; i++) begin
            s[2*i] = a[i];
        end
        return gf_reduce(s);
    endfunction

    // a^4
    function automatic logic [7:0] gf_pow4(input logic [7:0] a);
        return gf_sq(gf_sq(a));
    endfunction

    // AES affine map: b ^ rotl1 ^ rotl2 ^ rotl3 ^ rotl4 ^ 0x63
    function automatic logic [7:0] affine(input logic [7:0] b);
        return b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
                 ^ {b[3:0], b[7:4]} ^ AFFINE_ADD;
    endfunction

endpackage

>>> rtl/aes_sbox_compute.sv
// AES forward S-box, computed as GF(2^8) inverse followed by the affine map.
//
// Input channel : s_valid / s_ready / s_in_byte, one byte per word.
// Output channel: m_valid / m_ready / m_out_byte, one substituted byte per word.
//
// The inverse is taken as x^254 over three register stages, one field
// multiply deep each:
//   stage 1: x^3 = x^2 * x
//   stage 2: x^15 = x^12 * x^3 and x^14 = x^12 * x^2
//   stage 3: x^254 = x^240 * x^14, then the affine map into the output register
// m_valid is the stage 3 valid bit; an accepted word passes the stage 1 and
// stage 2 registers before it sets that bit. One word is taken every cycle
// while the receiver keeps up. Zero maps to zero, giving 0x63.
//
// Reset clears all stage valid bits; the payload registers are not reset.
// When m_ready is low the output word is held and earlier stages fill their
// empty slots; s_ready drops only once all three stages hold a word.
`include "aes_sbox_compute_defines.svh"

module aes_sbox_compute
    import asc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte
);

    // Stage valid bits and payload
    logic       v1_reg, v1_next;
    logic       v2_reg, v2_next;
    logic       v3_reg, v3_next;
    logic [7:0] x2_reg, x2_next;
    logic [7:0] x3_reg, x3_next;
    logic [7:0] x14_reg, x14_next;
    logic [7:0] x15_reg, x15_next;
    logic [7:0] out_reg, out_next;

    logic load1, load2, load3;
    logic [7:0] x12;
    logic [7:0] x240;
    logic [7:0] inv;

    // A stage loads when it is empty or its word moves on
    assign load3 = !v3_reg || m_ready;
    assign load2 = !v2_reg || load3;
    assign load1 = !v1_reg || load2;

    assign s_ready    = load1;
    assign m_valid    = v3_reg;
    assign m_out_byte = out_reg;

    // Stage 1: x^2 and x^3
    assign x2_next = gf_sq(s_in_byte);

    asc_gf_mul u_mul_x3 (
        .a (x2_next),
        .b (s_in_byte),
        .p (x3_next)
    );

    // Stage 2: x^15 and x^14 from x^12
    assign x12 = gf_pow4(x3_reg);

    asc_gf_mul u_mul_x15 (
        .a (x12),
        .b (x3_reg),
        .p (x15_next)
    );

    asc_gf_mul u_mul_x14 (
        .a (x12),
        .b (x2_reg),
        .p (x14_next)
    );

    // Stage 3: x^254 = x^240 * x^14, then affine
    assign x240 = gf_pow4(gf_pow4(x15_reg));

    asc_gf_mul u_mul_inv (
        .a (x240),
        .b (x14_reg),
        .p (inv)
    );

    assign out_next = affine(inv);

    // Valid bits advance with their stage
    always_comb begin
        v1_next = load1 ? s_valid : v1_reg;
        v2_next = load2 ? v1_reg  : v2_reg;
        v3_next = load3 ? v2_reg  : v3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        if (load1) begin
            x2_reg <= x2_next;
            x3_reg <= x3_next;
        end
        if (load2) begin
            x14_reg <= x14_next;
            x15_reg <= x15_next;
        end
        if (load3) begin
            out_reg <= out_next;
        end
    end

    // Checks
    `ASC_ASSERT_RST(a_reset_empties, !aresetn |=> !(v1_reg || v2_reg || m_valid), "reset not clean")
    `ASC_ASSERT(a_stage1_moves, v1_reg && load2 |=> v2_reg, "stage 1 word lost on advance")
    `ASC_ASSERT(a_stage2_moves, v2_reg && load3 |=> m_valid, "stage 2 word lost on advance")
    `ASC_ASSERT(a_full_stall, v1_reg && v2_reg && m_valid && !m_ready |-> !s_ready, "ready when full")

endmodule

>>> rtl/asc_gf_mul.sv
module asc_gf_mul
    import asc_pkg::*;
(
    input  logic [7:0] a,
    input  logic [7:0] b,
    output logic [7:0] p
);

    logic [14:0] prod;

    // Carry-less shift-and-add, then modular reduction
    always_comb begin
        prod = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                prod = prod ^ ({7'b0, a} << i);
            end
        end
        p = gf_reduce(prod);
    end

endmodule

>>> tb/tb_aes_sbox_compute.sv
`timescale 1ns / 1ps

module tb_aes_sbox_compute;

    // field reduction (x^8 folded back as x^4+x^3+x+1), affine offset, inverse exponent
    localparam logic [7:0] FIELD_FOLD = 8'h1B;
    localparam logic [7:0] AFFINE_XOR = 8'h63;
    localparam logic [7:0] INV_EXP    = 8'd254;
    localparam int         HOLD_LEN   = 60;
    localparam int         QUIET_MAX  = 2000;
    localparam int         TAIL_WAIT  = 10;

    logic       aclk       = 1'b0;
    logic       aresetn    = 1'b0;
    logic       s_valid    = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte  = 8'h00;
    logic       m_valid;
    logic       m_ready    = 1'b0;
    logic [7:0] m_out_byte;

    logic [7:0] byte_q[$];        // bytes waiting to be offered
    logic [7:0] sbox_exp_q[$];    // substitutions still owed by the block
    logic       in_fire     = 1'b0;
    int         snd_idle_pct = 0;
    int         rx_idle_pct  = 0;
    int         hold_req_n   = 0;
    int         hold_seen_n  = 0;
    int         hold_left    = 0;
    int         quiet_cnt    = 0;
    int         err_cnt      = 0;

    aes_sbox_compute dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // carry-less multiply, reduced one shift at a time
    function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] aa;
        acc = 8'h00;
        aa  = a;
        for (int n = 0; n < 8; n++) begin
            if (b[n]) acc = acc ^ aa;
            aa = {aa[6:0], 1'b0} ^ (aa[7] ? FIELD_FOLD : 8'h00);
        end
        return acc;
    endfunction

    // inverse as x^254 (zero stays zero), then the rotate-and-xor affine map
    function automatic logic [7:0] sbox_of(input logic [7:0] x);
        logic [7:0] r;
        logic [7:0] p;
        r = 8'h01;
        p = x;
        for (int k = 0; k < 8; k++) begin
            if (INV_EXP[k]) r = gf_times(r, p);
            p = gf_times(p, p);
        end
        return r ^ {r[6:0], r[7]} ^ {r[5:0], r[7:6]} ^ {r[4:0], r[7:5]}
                 ^ {r[3:0], r[7:4]} ^ AFFINE_XOR;
    endfunction

    task automatic flag_error(input string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    // sender: hold a word until taken, otherwise offer the next one or idle
    always @(negedge aclk) begin
        logic       nv;
        logic [7:0] nb;
        nb = s_in_byte;
        if (!aresetn) begin
            nv = 1'b0;
        end else if (s_valid && !in_fire) begin
            nv = 1'b1;
        end else if (byte_q.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
            nv = 1'b1;
            nb = byte_q.pop_front();
        end else begin
            nv = 1'b0;
        end
        s_valid   <= nv;
        s_in_byte <= nb;
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_seen_n != hold_req_n) begin
            hold_seen_n <= hold_req_n;
            hold_left   <= HOLD_LEN;
            m_ready     <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // monitor: predict on input words, check output words in order
    always @(posedge aclk) begin
        logic [7:0] want;
        if (!aresetn) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= s_valid && s_ready;
            if (s_valid && s_ready) sbox_exp_q.push_back(sbox_of(s_in_byte));
            if (m_valid && m_ready) begin
                if (sbox_exp_q.size() == 0) begin
                    flag_error($sformatf("unexpected word 0x%02h", m_out_byte));
                end else begin
                    want = sbox_exp_q.pop_front();
                    if (m_out_byte !== want)
                        flag_error($sformatf("out_byte got 0x%02h want 0x%02h",
                                             m_out_byte, want));
                end
            end
        end
    end

    // watchdog: only counts while work is outstanding
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)
                || (byte_q.size() == 0 && sbox_exp_q.size() == 0 && !s_valid)) begin
                quiet_cnt <= 0;
            end else if (quiet_cnt >= QUIET_MAX) begin
                $display("RESULT: ERROR");
                $finish;
            end else begin
                quiet_cnt <= quiet_cnt + 1;
            end
        end
    end

    // sender pauses here until every owed word has come back
    task automatic drain;
        do begin
            @(posedge aclk);
            #1;
        end while (byte_q.size() != 0 || s_valid || sbox_exp_q.size() != 0);
    endtask

    task automatic push_random(input int n);
        repeat (n) byte_q.push_back(8'($urandom_range(255)));
    endtask

    initial begin
        logic [7:0] corner[$];
        corner = '{8'h00, 8'h01, 8'hFF, 8'h80, 8'h7F, 8'h55, 8'hAA, 8'h02, 8'h04,
                   8'h08, 8'h10, 8'h20, 8'h40, 8'h53, 8'hCA, 8'hFE, 8'h03, 8'hF0,
                   8'h0F, 8'h00};

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: zero, extremes, single bits, a known inverse pair
        snd_idle_pct = 9;
        rx_idle_pct  = 69;
        foreach (corner[i]) byte_q.push_back(corner[i]);
        drain();

        // back-pressure: receiver holds off while the sender keeps offering
        @(posedge aclk);
        snd_idle_pct = 0;
        hold_req_n++;
        push_random(40);
        drain();

        // slow receiver
        snd_idle_pct = 9;
        rx_idle_pct  = 69;
        push_random(500);
        drain();

        // slow sender
        snd_idle_pct = 69;
        rx_idle_pct  = 9;
        push_random(500);
        drain();

        // full rate: every byte once, then random
        snd_idle_pct = 0;
        rx_idle_pct  = 0;
        for (int v = 0; v < 256; v++) byte_q.push_back(8'(v));
        push_random(250);
        drain();

        repeat (TAIL_WAIT) @(posedge aclk);
        if (sbox_exp_q.size() != 0)
            flag_error($sformatf("%0d words never arrived", sbox_exp_q.size()));
        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> aes_sbox_compute.f
+incdir+rtl
rtl/asc_pkg.sv
rtl/asc_gf_mul.sv
rtl/aes_sbox_compute.sv
tb/tb_aes_sbox_compute.sv
